@@ rtl/decaying_priority_slot_replacer_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the decaying-priority slot replacer.
// ----------------------------------------------------------------------------
`ifndef DECAYING_PRIORITY_SLOT_REPLACER_TOP_MACROS_SVH
`define DECAYING_PRIORITY_SLOT_REPLACER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define DPSR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define DPSR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/dpsr_pkg.sv @@
// ----------------------------------------------------------------------------
// dpsr_pkg
// Types and constants shared by the decaying-priority slot replacer.
// ----------------------------------------------------------------------------
package dpsr_pkg;

	localparam int ENTRIES  = 8;
	localparam int KEY_BITS = 16;
	localparam int SIDES    = 2;
	localparam int SLOT_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int SLOT_NP  = 2 ** SLOT_W;
	localparam int PRIO_W   = 16;

	localparam logic [PRIO_W-1:0] PRIO_ONE    = 16'd8192;
	localparam logic [PRIO_W-1:0] PRIO_MAX    = 16'hFFFF;
	localparam logic [15:0]       DECAY_RESET = 16'd52429;

	localparam logic OP_KEY  = 1'b0;
	localparam logic OP_SLOT = 1'b1;

	typedef enum logic [1:0] {
		STATUS_HIT  = 2'd0,
		STATUS_MISS = 2'd1,
		STATUS_BAD  = 2'd2
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_LOOK
	} state_t;

	typedef struct packed {
		logic        opcode;
		logic        side;
		logic [15:0] key;
		logic [3:0]  slot;
	} req_t;

	typedef struct packed {
		logic [3:0]  chosen_slot;
		logic [15:0] chosen_key;
		logic [1:0]  status;
	} rsp_t;

	typedef logic [ENTRIES-1:0][KEY_BITS-1:0] key_row_t;
	typedef logic [ENTRIES-1:0][PRIO_W-1:0]   prio_row_t;

endpackage

@@ rtl/dpsr_ram.sv @@
// ----------------------------------------------------------------------------
// dpsr_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dpsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/decaying_priority_slot_replacer_top.sv @@
// ----------------------------------------------------------------------------
// decaying_priority_slot_replacer_top
// Two tables of keyed slots with aging priorities and lowest-priority refill.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the req channel (req_valid / req_stall, payload req).
// A beat is taken when req_valid is high and req_stall is low. Each request
// produces exactly one response beat on rsp (rsp_valid / rsp_stall).
// The aging factor is written through cfg_valid / cfg_ready / cfg_data; the
// port is always ready and should only be written while the block is idle.
// The response is registered. A new request is taken only in the idle state,
// once the previous one is done: the block first reads the side's key row
// and priority row from memory, then searches the row for a hit or the
// lowest priority, ages every slot and writes both rows back. If rsp_stall
// holds a response in the output register, the next request is still taken;
// its update waits until the output register is free.
// Reset clears the slot valid bits and the per-side priority-row valid bits,
// so keys and priorities read as zero without a clearing pass; the aging
// factor returns to 0.8 (52429 in Q0.16).
// ----------------------------------------------------------------------------
`include "decaying_priority_slot_replacer_top_macros.svh"

module decaying_priority_slot_replacer_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  dpsr_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output dpsr_pkg::rsp_t rsp,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [15:0]    cfg_data
);

	localparam int NODES = 2 * dpsr_pkg::SLOT_NP;

	dpsr_pkg::state_t state_q, state_d;
	dpsr_pkg::req_t   req_s1;
	dpsr_pkg::rsp_t   rsp_q, rsp_d;
	logic             rsp_valid_q;
	logic [15:0]      decay_q;

	logic [dpsr_pkg::SIDES-1:0][dpsr_pkg::ENTRIES-1:0] slot_vld_q;
	logic [dpsr_pkg::SIDES-1:0]                        prio_vld_q;

	logic                req_acc;
	logic                ram_re;
	logic                look_done;
	logic                ram_we;
	dpsr_pkg::key_row_t  key_rdata, key_wdata, key_cur;
	dpsr_pkg::prio_row_t prio_rdata, prio_wdata, prio_cur;

	logic [dpsr_pkg::ENTRIES-1:0]  match;
	logic                          hit;
	logic                          bad;
	logic                          miss;
	logic [dpsr_pkg::SLOT_W-1:0]   hit_idx;
	logic [dpsr_pkg::SLOT_W-1:0]   min_idx;
	logic [dpsr_pkg::SLOT_W-1:0]   chosen;
	logic [dpsr_pkg::KEY_BITS-1:0] key_in;
	logic [dpsr_pkg::PRIO_W-1:0]   tree_val [1:NODES-1];
	logic [dpsr_pkg::SLOT_W-1:0]   tree_idx [1:NODES-1];
	logic [dpsr_pkg::PRIO_W:0]     gain_sum;
	logic [31:0]                   prod [dpsr_pkg::ENTRIES];

	assign cfg_ready = 1'b1;
	assign req_acc   = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q <= dpsr_pkg::DECAY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			decay_q <= cfg_data;
		end
	end

	dpsr_ram #(
		.WIDTH($bits(dpsr_pkg::key_row_t)),
		.DEPTH(dpsr_pkg::SIDES)
	) u_key_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(req_s1.side),
		.wdata(key_wdata),
		.re   (ram_re),
		.raddr(req.side),
		.rdata(key_rdata)
	);

	dpsr_ram #(
		.WIDTH($bits(dpsr_pkg::prio_row_t)),
		.DEPTH(dpsr_pkg::SIDES)
	) u_prio_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(req_s1.side),
		.wdata(prio_wdata),
		.re   (ram_re),
		.raddr(req.side),
		.rdata(prio_rdata)
	);

	// Search, aging and write-back data for the request held in req_s1.
	always_comb begin
		key_in = dpsr_pkg::KEY_BITS'(req_s1.key);
		for (int k = 0; k < dpsr_pkg::ENTRIES; k++) begin
			key_cur[k]  = slot_vld_q[req_s1.side][k] ? key_rdata[k] : '0;
			prio_cur[k] = prio_vld_q[req_s1.side] ? prio_rdata[k] : '0;
			match[k]    = slot_vld_q[req_s1.side][k] && (key_rdata[k] == key_in);
		end

		hit     = |match;
		hit_idx = '0;
		for (int k = dpsr_pkg::ENTRIES - 1; k >= 0; k--) begin
			if (match[k]) begin
				hit_idx = dpsr_pkg::SLOT_W'(k);
			end
		end

		// Minimum tree; padding leaves sit to the right and never win a compare.
		for (int n = 0; n < dpsr_pkg::SLOT_NP; n++) begin
			tree_val[dpsr_pkg::SLOT_NP + n] = (n < dpsr_pkg::ENTRIES) ?
				prio_cur[n] : dpsr_pkg::PRIO_MAX;
			tree_idx[dpsr_pkg::SLOT_NP + n] = dpsr_pkg::SLOT_W'(n);
		end
		for (int n = dpsr_pkg::SLOT_NP - 1; n >= 1; n--) begin
			if (tree_val[2 * n + 1] < tree_val[2 * n]) begin
				tree_val[n] = tree_val[2 * n + 1];
				tree_idx[n] = tree_idx[2 * n + 1];
			end else begin
				tree_val[n] = tree_val[2 * n];
				tree_idx[n] = tree_idx[2 * n];
			end
		end
		min_idx = tree_idx[1];

		bad  = (req_s1.opcode == dpsr_pkg::OP_SLOT) &&
			((req_s1.slot == 4'd0) || (int'(req_s1.slot) > dpsr_pkg::ENTRIES));
		miss = (req_s1.opcode == dpsr_pkg::OP_KEY) && !hit;

		if (req_s1.opcode == dpsr_pkg::OP_SLOT) begin
			chosen = dpsr_pkg::SLOT_W'(req_s1.slot - 4'd1);
		end else if (hit) begin
			chosen = hit_idx;
		end else begin
			chosen = min_idx;
		end

		key_wdata = key_cur;
		if (miss) begin
			key_wdata[chosen] = key_in;
		end

		gain_sum = {1'b0, prio_cur[chosen]} + {1'b0, dpsr_pkg::PRIO_ONE};
		for (int k = 0; k < dpsr_pkg::ENTRIES; k++) begin
			prod[k] = 32'(prio_cur[k]) * 32'(decay_q);
			if (dpsr_pkg::SLOT_W'(k) == chosen) begin
				prio_wdata[k] = gain_sum[dpsr_pkg::PRIO_W] ? dpsr_pkg::PRIO_MAX :
					gain_sum[dpsr_pkg::PRIO_W-1:0];
			end else begin
				prio_wdata[k] = prod[k][31:16];
			end
		end

		if (bad) begin
			rsp_d.chosen_slot = 4'd0;
			rsp_d.chosen_key  = 16'd0;
			rsp_d.status      = dpsr_pkg::STATUS_BAD;
		end else begin
			rsp_d.chosen_slot = 4'(({1'b0, chosen}) + 1'b1);
			rsp_d.chosen_key  = 16'(key_wdata[chosen]);
			rsp_d.status      = miss ? dpsr_pkg::STATUS_MISS : dpsr_pkg::STATUS_HIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dpsr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		ram_re    = 1'b0;
		look_done = 1'b0;
		ram_we    = 1'b0;
		unique case (state_q)
			dpsr_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				ram_re    = req_valid;
				if (req_valid) begin
					state_d = dpsr_pkg::ST_LOOK;
				end
			end
			dpsr_pkg::ST_LOOK: begin
				// Hold the update until the output register can take the beat.
				look_done = !(rsp_valid_q && rsp_stall);
				ram_we    = look_done && !bad;
				if (look_done) begin
					state_d = dpsr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dpsr_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			req_s1 <= req;
		end
		if (look_done) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			slot_vld_q  <= '0;
			prio_vld_q  <= '0;
		end else begin
			if (look_done) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (ram_we) begin
				prio_vld_q[req_s1.side] <= 1'b1;
				if (miss) begin
					slot_vld_q[req_s1.side][chosen] <= 1'b1;
				end
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`DPSR_ASSERT_NEXT(a_accept_to_look, req_acc, state_q == dpsr_pkg::ST_LOOK, "beat not looked up")
	`DPSR_ASSERT_NEXT(a_done_loads_rsp, look_done, rsp_valid_q, "finished request gave no response")
	`DPSR_ASSERT_NEXT(a_wait_holds_req, (state_q == dpsr_pkg::ST_LOOK) && !look_done,
		(state_q == dpsr_pkg::ST_LOOK) && $stable(req_s1), "pending request lost while waiting")
	`DPSR_ASSERT_NOW(a_no_write_on_bad, bad && (state_q == dpsr_pkg::ST_LOOK), !ram_we,
		"bad slot request wrote the tables")

endmodule

@@ tb/sv/decaying_priority_slot_replacer_top_tb.sv @@
// ----------------------------------------------------------------------------
// decaying_priority_slot_replacer_top_tb
// Self-checking bench for the two-sided keyed slot table with aging priorities.
// Requests come from a queue and are sent in random bursts. The response side
// stalls on its own random pattern. Each accepted request runs through a local
// copy of both tables, and the predicted response waits in order for the
// monitor. The aging factor is rewritten between phases, at its extremes too.
// ----------------------------------------------------------------------------
module decaying_priority_slot_replacer_top_tb;

	localparam int CLK_PERIOD  = 12;
	localparam int POOL_KEYS   = 12;
	localparam int PHASE_ITEMS = 290;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           req_valid = 1'b0;
	logic           req_stall;
	dpsr_pkg::req_t req = '0;
	logic           rsp_valid;
	logic           rsp_stall = 1'b0;
	dpsr_pkg::rsp_t rsp;
	logic           cfg_valid = 1'b0;
	logic           cfg_ready;
	logic [15:0]    cfg_data = '0;

	// Local copy of both tables and the aging factor.
	logic [15:0] tbl_key   [dpsr_pkg::SIDES][dpsr_pkg::ENTRIES];
	logic        tbl_valid [dpsr_pkg::SIDES][dpsr_pkg::ENTRIES];
	logic [15:0] tbl_prio  [dpsr_pkg::SIDES][dpsr_pkg::ENTRIES];
	logic [15:0] decay_now = dpsr_pkg::DECAY_RESET;

	dpsr_pkg::req_t pending_lookups[$];
	dpsr_pkg::rsp_t predicted_choices[$];
	logic [15:0]    key_pool[POOL_KEYS];
	int             mismatch_count = 0;

	int          burst_left = 0;
	int          gap_left = 0;
	int          stall_run = 0;
	int          stall_pct = 0;

	decaying_priority_slot_replacer_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		for (int s = 0; s < dpsr_pkg::SIDES; s++) begin
			for (int k = 0; k < dpsr_pkg::ENTRIES; k++) begin
				tbl_key[s][k]   = '0;
				tbl_valid[s][k] = 1'b0;
				tbl_prio[s][k]  = '0;
			end
		end
	end

	// Finds or fills the slot for one request, then ages that side; a bad slot number changes nothing.
	function automatic dpsr_pkg::rsp_t select_and_age(dpsr_pkg::req_t r);
		dpsr_pkg::rsp_t o;
		int             s;
		int             pick;
		bit             found;
		logic [15:0]    least;
		logic [16:0]    sum;
		logic [31:0]    prod;
		o = '0;
		s = int'(r.side);
		pick = 0;
		found = 1'b0;
		if (r.opcode == dpsr_pkg::OP_SLOT) begin
			if (r.slot == 0 || r.slot > dpsr_pkg::ENTRIES) begin
				o.status = dpsr_pkg::STATUS_BAD;
				return o;
			end
			pick = int'(r.slot) - 1;
			o.status = dpsr_pkg::STATUS_HIT;
		end else begin
			for (int k = 0; k < dpsr_pkg::ENTRIES; k++) begin
				if (!found && tbl_valid[s][k] && tbl_key[s][k] == r.key) begin
					pick = k;
					found = 1'b1;
				end
			end
			if (found) begin
				o.status = dpsr_pkg::STATUS_HIT;
			end else begin
				// Lowest priority wins; strict compare keeps the lowest-numbered slot on a tie.
				least = tbl_prio[s][0];
				for (int k = 1; k < dpsr_pkg::ENTRIES; k++) begin
					if (tbl_prio[s][k] < least) begin
						least = tbl_prio[s][k];
						pick = k;
					end
				end
				tbl_key[s][pick] = r.key;
				tbl_valid[s][pick] = 1'b1;
				o.status = dpsr_pkg::STATUS_MISS;
			end
		end
		for (int k = 0; k < dpsr_pkg::ENTRIES; k++) begin
			if (k == pick) begin
				sum = {1'b0, tbl_prio[s][k]} + {1'b0, dpsr_pkg::PRIO_ONE};
				tbl_prio[s][k] = sum[16] ? dpsr_pkg::PRIO_MAX : sum[15:0];
			end else begin
				prod = tbl_prio[s][k] * decay_now;
				tbl_prio[s][k] = prod[31:16];
			end
		end
		o.chosen_slot = 4'(pick + 1);
		o.chosen_key = tbl_key[s][pick];
		return o;
	endfunction

	function automatic dpsr_pkg::req_t mk_req(logic op, logic sd, logic [15:0] k,
		logic [3:0] sl);
		dpsr_pkg::req_t r;
		r.opcode = op;
		r.side = sd;
		r.key = k;
		r.slot = sl;
		return r;
	endfunction

	// Mostly lookups from a small key pool so hits, refills and evictions all occur.
	function automatic dpsr_pkg::req_t random_lookup();
		dpsr_pkg::req_t r;
		int             pick;
		r = mk_req(dpsr_pkg::OP_KEY, 1'($urandom), 16'($urandom), 4'($urandom));
		pick = $urandom_range(0, 99);
		if (pick < 55)
			r.key = key_pool[$urandom_range(0, POOL_KEYS - 1)];
		else if (pick < 65)
			r.key = 16'($urandom);
		else if (pick < 90) begin
			r.opcode = dpsr_pkg::OP_SLOT;
			r.slot = 4'($urandom_range(1, dpsr_pkg::ENTRIES));
		end else begin
			r.opcode = dpsr_pkg::OP_SLOT;
			r.slot = 4'($urandom_range(0, 15));
		end
		return r;
	endfunction

	// Request driver: bursts of random length separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && !req_stall)
				predicted_choices.push_back(select_and_age(req));
			if (!req_valid || !req_stall) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					req_valid <= 1'b0;
				end else if (pending_lookups.size() > 0) begin
					req <= pending_lookups.pop_front();
					req_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 24);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor; also drives the stall, whose density changes from run to run.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (predicted_choices.size() == 0) begin
					mismatch_count++;
					$display("%0t: expected none, got slot=%0d key=%h status=%0d",
						$time, rsp.chosen_slot, rsp.chosen_key, rsp.status);
				end else if (rsp !== predicted_choices[0]) begin
					mismatch_count++;
					$display("%0t: expected slot=%0d key=%h status=%0d, got slot=%0d key=%h status=%0d",
						$time, predicted_choices[0].chosen_slot,
						predicted_choices[0].chosen_key, predicted_choices[0].status,
						rsp.chosen_slot, rsp.chosen_key, rsp.status);
					void'(predicted_choices.pop_front());
				end else begin
					void'(predicted_choices.pop_front());
				end
			end
			if (stall_run <= 0) begin
				stall_run <= $urandom_range(10, 200);
				case ($urandom_range(0, 3))
					0: stall_pct <= 0;
					1: stall_pct <= 25;
					2: stall_pct <= 50;
					default: stall_pct <= 85;
				endcase
			end else begin
				stall_run <= stall_run - 1;
			end
			rsp_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	task automatic wait_idle();
		do @(negedge clk);
		while (pending_lookups.size() != 0 || predicted_choices.size() != 0 || req_valid);
	endtask

	task automatic write_decay(logic [15:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		decay_now = v;
	endtask

	initial begin
		logic [15:0] decay_plan[6];
		decay_plan = '{16'hFFFF, 16'h0000, 16'($urandom), 16'h0001, 16'h8000,
			dpsr_pkg::DECAY_RESET};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: bad slot numbers, an empty slot, key zero on empty slots,
		// a repeat key that hits on side one, the same key on side zero, a full table, then saturation of one slot.
		pending_lookups.push_back(mk_req(dpsr_pkg::OP_SLOT, 1'b0, 16'hA5A5, 4'd0));
		pending_lookups.push_back(mk_req(dpsr_pkg::OP_SLOT, 1'b1, 16'hFFFF, 4'd9));
		pending_lookups.push_back(mk_req(dpsr_pkg::OP_SLOT, 1'b0, 16'h0000, 4'd15));
		pending_lookups.push_back(mk_req(dpsr_pkg::OP_SLOT, 1'b0, 16'h1234, 4'd3));
		pending_lookups.push_back(mk_req(dpsr_pkg::OP_KEY, 1'b0, 16'h0000, 4'd15));
		pending_lookups.push_back(mk_req(dpsr_pkg::OP_KEY, 1'b1, 16'hFFFF, 4'd0));
		pending_lookups.push_back(mk_req(dpsr_pkg::OP_KEY, 1'b1, 16'hFFFF, 4'd8));
		pending_lookups.push_back(mk_req(dpsr_pkg::OP_KEY, 1'b0, 16'hFFFF, 4'd1));
		for (int k = 0; k < dpsr_pkg::ENTRIES; k++)
			pending_lookups.push_back(mk_req(dpsr_pkg::OP_KEY, 1'b0,
				16'(16'h1000 * k + 7), 4'(k)));
		for (int k = 0; k < 9; k++)
			pending_lookups.push_back(mk_req(dpsr_pkg::OP_SLOT, 1'b1, 16'(~k),
				4'(dpsr_pkg::ENTRIES)));
		wait_idle();

		foreach (decay_plan[p]) begin
			write_decay(decay_plan[p]);
			foreach (key_pool[i])
				key_pool[i] = 16'($urandom);
			@(negedge clk);
			repeat (PHASE_ITEMS)
				pending_lookups.push_back(random_lookup());
			wait_idle();
		end

		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && predicted_choices.size() == 0)
			$display("decaying_priority_slot_replacer_top regression: pass");
		else
			$display("decaying_priority_slot_replacer_top regression: fail");
		$finish;
	end

	initial begin
		#6000000;
		$display("decaying_priority_slot_replacer_top regression: fail");
		$finish;
	end

endmodule
